### design/tqla_pkg.sv
// tqla_pkg: shared types and constants for the q-learning agent
// no dependencies; used by tqla_csr, tabular_q_learning_agent_unit and both testbench files
`default_nettype none
package tqla_pkg;

   localparam int CSR_AW = 5;
   localparam int STATE_IN_W = 6;

   typedef enum logic [1:0] {
      MODE_NEW_RUN  = 2'd0,
      MODE_BEGIN    = 2'd1,
      MODE_FEEDBACK = 2'd2,
      MODE_NONE     = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      REG_STEP_SIZE  = 3'd0,
      REG_DISCOUNT   = 3'd1,
      REG_EPS_START  = 3'd2,
      REG_EPS_FLOOR  = 3'd3,
      REG_EPS_DECAY  = 3'd4,
      REG_MAX_STEPS  = 3'd5,
      REG_RNG_SEED   = 3'd6,
      REG_UNUSED     = 3'd7
   } reg_index_type;

   localparam logic [15:0] STEP_SIZE_RST  = 16'd6554;
   localparam logic [15:0] DISCOUNT_RST   = 16'd64881;
   localparam logic [30:0] EPS_START_RST  = 31'd2147483647;
   localparam logic [30:0] EPS_FLOOR_RST  = 31'd21474836;
   localparam logic [15:0] EPS_DECAY_RST  = 16'd65470;
   localparam logic [15:0] MAX_STEPS_RST  = 16'd100;
   localparam logic [30:0] RNG_SEED_RST   = 31'd1;
   localparam logic [30:0] RNG_RST        = 31'd1;

   localparam logic [30:0] LCG_MUL = 31'd1103515245;
   localparam logic [30:0] LCG_ADD = 31'd12345;

   typedef struct packed {
      logic [15:0] step_size;
      logic [15:0] discount;
      logic [30:0] eps_start;
      logic [30:0] eps_floor;
      logic [15:0] eps_decay;
      logic [15:0] max_steps;
      logic [30:0] rng_seed;
   } cfg_type;

   function automatic logic [30:0] lcg_next(input logic [30:0] x);
      lcg_next = x * LCG_MUL + LCG_ADD;
   endfunction

endpackage
`default_nettype wire

### design/tqla_csr.sv
// tqla_csr: apb-style register file for the agent's learning parameters
// depends on tqla_pkg
`default_nettype none
module tqla_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [tqla_pkg::CSR_AW-1:0]   paddr,
   input  wire logic [31:0]                   pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready,
   output tqla_pkg::cfg_type                  cfg
);
   import tqla_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type idx;
   logic          wr_en;

   assign idx    = reg_index_type'(paddr[4:2]);
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_size  <= STEP_SIZE_RST;
         cfg_ff.discount   <= DISCOUNT_RST;
         cfg_ff.eps_start  <= EPS_START_RST;
         cfg_ff.eps_floor  <= EPS_FLOOR_RST;
         cfg_ff.eps_decay  <= EPS_DECAY_RST;
         cfg_ff.max_steps  <= MAX_STEPS_RST;
         cfg_ff.rng_seed   <= RNG_SEED_RST;
      end else if (wr_en) begin
         case (idx)
            REG_STEP_SIZE:  cfg_ff.step_size  <= pwdata[15:0];
            REG_DISCOUNT:   cfg_ff.discount   <= pwdata[15:0];
            REG_EPS_START:  cfg_ff.eps_start  <= pwdata[30:0];
            REG_EPS_FLOOR:  cfg_ff.eps_floor  <= pwdata[30:0];
            REG_EPS_DECAY:  cfg_ff.eps_decay  <= pwdata[15:0];
            REG_MAX_STEPS:  cfg_ff.max_steps  <= pwdata[15:0];
            REG_RNG_SEED:   cfg_ff.rng_seed   <= pwdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_STEP_SIZE:  prdata = {16'd0, cfg_ff.step_size};
         REG_DISCOUNT:   prdata = {16'd0, cfg_ff.discount};
         REG_EPS_START:  prdata = {1'b0, cfg_ff.eps_start};
         REG_EPS_FLOOR:  prdata = {1'b0, cfg_ff.eps_floor};
         REG_EPS_DECAY:  prdata = {16'd0, cfg_ff.eps_decay};
         REG_MAX_STEPS:  prdata = {16'd0, cfg_ff.max_steps};
         REG_RNG_SEED:   prdata = {1'b0, cfg_ff.rng_seed};
         default:        prdata = 32'd0;
      endcase
   end

endmodule
`default_nettype wire

### design/tabular_q_learning_agent_unit.sv
// tabular_q_learning_agent_unit: q-table agent with epsilon-greedy action choice
// depends on tqla_pkg and tqla_csr
//
//   channel  | ports                                        | transfer
//   ---------+----------------------------------------------+---------------------------
//   request  | req_mode, req_next_state, req_reward, req_done_req | start high, busy low
//   response | rsp_action, rsp_explored, rsp_episode_over   | rsp_valid high, one cycle
//   config   | psel penable pwrite paddr pwdata prdata pready | apb access phase
//
// feedback: MAXQ, DISC, DIFF, SCALE, WRITE, then DRAW1 and, for a second random draw,
// DRAW2; at episode end WRITE gives the result, or DECAY with epsilon decay; the
// single-port row memory (two row reads, one write) and two multiplies set these steps
// begin episode: LOAD, DRAW1, maybe DRAW2; new run: CLEAR of all rows, then the draws
// after reset a clearing pass over all NUM_STATES rows runs with busy high
// the result receiver cannot stall; a new item may start while a result shows
`default_nettype none
module tabular_q_learning_agent_unit #(
   parameter int NUM_STATES  = 64,
   parameter int NUM_ACTIONS = 4,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic [1:0]                          req_mode,
   input  wire logic [tqla_pkg::STATE_IN_W-1:0]     req_next_state,
   input  wire logic signed [7:0]                   req_reward,
   input  wire logic                                req_done_req,
   output logic                                     rsp_valid,
   output logic [1:0]                               rsp_action,
   output logic                                     rsp_explored,
   output logic                                     rsp_episode_over,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [tqla_pkg::CSR_AW-1:0]         paddr,
   input  wire logic [31:0]                         pwdata,
   output logic [31:0]                              prdata,
   output logic                                     pready
);
   import tqla_pkg::*;

   localparam int VW    = VALUE_WIDTH;
   localparam int AW    = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
   localparam int ROW_W = NUM_ACTIONS * VW;
   localparam int TW    = ((VW > 24) ? VW : 24) + 2;
   localparam int DW    = TW + 1;
   localparam int PW    = DW + 17;
   localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
   localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_CLEAR = 11'b000_0000_0010,
      ST_LOAD  = 11'b000_0000_0100,
      ST_MAXQ  = 11'b000_0000_1000,
      ST_DISC  = 11'b000_0001_0000,
      ST_DIFF  = 11'b000_0010_0000,
      ST_SCALE = 11'b000_0100_0000,
      ST_WRITE = 11'b000_1000_0000,
      ST_DRAW1 = 11'b001_0000_0000,
      ST_DRAW2 = 11'b010_0000_0000,
      ST_DECAY = 11'b100_0000_0000
   } state_type;

   cfg_type cfg;

   tqla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // row memory: one word per state holds all action values
   logic [ROW_W-1:0] mem [NUM_STATES];
   logic [ROW_W-1:0] rd_ff;
   logic [AW-1:0]    mem_addr;
   logic             mem_we;
   logic [ROW_W-1:0] mem_wdata;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_cnt_ff, clr_cnt_in;
   logic                   new_run_ff, new_run_in;
   logic [AW-1:0]          cur_ff, cur_in;
   logic [AW-1:0]          nxt_ff, nxt_in;
   logic [1:0]             last_act_ff, last_act_in;
   logic [30:0]            eps_ff, eps_in;
   logic [30:0]            rng_ff, rng_in;
   logic [15:0]            step_ff, step_in;
   logic signed [7:0]      reward_ff, reward_in;
   logic                   done_ff, done_in;
   logic [ROW_W-1:0]       nrow_ff, nrow_in;
   logic [ROW_W-1:0]       crow_ff, crow_in;
   logic [ROW_W-1:0]       chrow_ff, chrow_in;
   logic [VW-1:0]          maxq_ff, maxq_in;
   logic signed [TW-1:0]   target_ff, target_in;
   logic signed [DW-1:0]   diff_ff, diff_in;
   logic signed [PW-1:0]   delta_ff, delta_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [1:0]             rsp_action_ff, rsp_action_in;
   logic                   rsp_explored_ff, rsp_explored_in;
   logic                   rsp_over_ff, rsp_over_in;

   function automatic logic [AW-1:0] wrap_state(input logic [STATE_IN_W-1:0] v);
      logic [AW-1:0] r;
      r = '0;
      for (int i = 0; i < 2**STATE_IN_W; i++) begin
         if (v == STATE_IN_W'(i)) r = AW'(i % NUM_STATES);
      end
      return r;
   endfunction

   // largest value in a row, floored at zero; index of its first occurrence above zero, else 0
   function automatic logic [VW-1:0] row_max(input logic [ROW_W-1:0] row);
      logic signed [VW-1:0] best;
      best = '0;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         if ($signed(row[i*VW +: VW]) > best) best = $signed(row[i*VW +: VW]);
      end
      return best;
   endfunction

   function automatic logic [1:0] row_argmax(input logic [ROW_W-1:0] row);
      logic signed [VW-1:0] best;
      logic [1:0]           idx;
      best = '0;
      idx  = '0;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         if ($signed(row[i*VW +: VW]) > best) begin
            best = $signed(row[i*VW +: VW]);
            idx  = 2'(i);
         end
      end
      return idx;
   endfunction

   function automatic logic [1:0] act_mod(input logic [30:0] r);
      logic [5:0]  dsum;
      logic [1:0]  m;
      logic [31:0] rx;
      dsum = '0;
      m    = '0;
      rx   = {1'b0, r};
      if (NUM_ACTIONS == 3) begin
         // 4 = 1 mod 3, so base-4 digits sum to the same residue
         for (int i = 0; i < 16; i++) dsum = dsum + 6'(rx[2*i +: 2]);
         for (int i = 0; i < 64; i++) begin
            if (dsum == 6'(i)) m = 2'(i % 3);
         end
      end else begin
         m = r[1:0] & 2'(NUM_ACTIONS - 1);
      end
      return m;
   endfunction

   logic signed [VW-1:0]  q_sel;
   logic [VW+15:0]        disc_prod;
   logic signed [TW-1:0]  rew_ext;
   logic signed [PW-1:0]  scale_prod;
   logic signed [PW-1:0]  new_sum;
   logic signed [VW-1:0]  new_val;
   logic [ROW_W-1:0]      new_row;
   logic [30:0]           draw;
   logic [46:0]           decay_prod;
   logic [15:0]           step_inc;
   mode_type              mode;

   assign mode = mode_type'(req_mode);
   assign draw = lcg_next(rng_ff);

   always_comb begin
      q_sel = '0;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         if (last_act_ff == 2'(i)) q_sel = $signed(crow_ff[i*VW +: VW]);
      end
   end

   assign disc_prod  = maxq_ff * cfg.discount;
   assign rew_ext    = TW'(reward_ff);
   assign scale_prod = PW'(diff_ff) * $signed({1'b0, cfg.step_size});
   assign new_sum    = PW'(q_sel) + delta_ff;
   assign decay_prod = eps_ff * cfg.eps_decay;
   assign step_inc   = (step_ff != 16'hFFFF) ? step_ff + 16'd1 : step_ff;

   always_comb begin
      if (new_sum > PW'(VMAX))      new_val = VMAX;
      else if (new_sum < PW'(VMIN)) new_val = VMIN;
      else                          new_val = VW'(new_sum);
      new_row = crow_ff;
      for (int i = 0; i < NUM_ACTIONS; i++) begin
         if (last_act_ff == 2'(i)) new_row[i*VW +: VW] = new_val;
      end
   end

   always_comb begin
      state_in        = state_ff;
      clr_cnt_in      = clr_cnt_ff;
      new_run_in      = new_run_ff;
      cur_in          = cur_ff;
      nxt_in          = nxt_ff;
      last_act_in     = last_act_ff;
      eps_in          = eps_ff;
      rng_in          = rng_ff;
      step_in         = step_ff;
      reward_in       = reward_ff;
      done_in         = done_ff;
      nrow_in         = nrow_ff;
      crow_in         = crow_ff;
      chrow_in        = chrow_ff;
      maxq_in         = maxq_ff;
      target_in       = target_ff;
      diff_in         = diff_ff;
      delta_in        = delta_ff;
      rsp_valid_in    = 1'b0;
      rsp_action_in   = rsp_action_ff;
      rsp_explored_in = rsp_explored_ff;
      rsp_over_in     = rsp_over_ff;
      mem_addr        = cur_ff;
      mem_we          = 1'b0;
      mem_wdata       = new_row;

      case (state_ff)
         ST_IDLE: begin
            mem_addr = (mode == MODE_FEEDBACK) ? wrap_state(req_next_state) : '0;
            if (start) begin
               nxt_in    = wrap_state(req_next_state);
               reward_in = req_reward;
               done_in   = req_done_req;
               case (mode)
                  MODE_NEW_RUN: begin
                     eps_in     = cfg.eps_start;
                     rng_in     = cfg.rng_seed;
                     cur_in     = '0;
                     step_in    = '0;
                     clr_cnt_in = '0;
                     new_run_in = 1'b1;
                     state_in   = ST_CLEAR;
                  end
                  MODE_BEGIN: begin
                     cur_in   = '0;
                     step_in  = '0;
                     state_in = ST_LOAD;
                  end
                  MODE_FEEDBACK: state_in = ST_MAXQ;
                  default: begin
                     rsp_valid_in    = 1'b1;
                     rsp_action_in   = '0;
                     rsp_explored_in = 1'b0;
                     rsp_over_in     = 1'b0;
                  end
               endcase
            end
         end
         ST_CLEAR: begin
            mem_addr   = clr_cnt_ff;
            mem_we     = 1'b1;
            mem_wdata  = '0;
            clr_cnt_in = clr_cnt_ff + AW'(1);
            if (clr_cnt_ff == AW'(NUM_STATES - 1)) begin
               chrow_in = '0;
               state_in = new_run_ff ? ST_DRAW1 : ST_IDLE;
            end
         end
         ST_LOAD: begin
            chrow_in = rd_ff;
            state_in = ST_DRAW1;
         end
         ST_MAXQ: begin
            mem_addr = cur_ff;
            nrow_in  = rd_ff;
            maxq_in  = row_max(rd_ff);
            state_in = ST_DISC;
         end
         ST_DISC: begin
            crow_in   = rd_ff;
            target_in = (rew_ext <<< 16) + $signed(TW'(disc_prod[VW+15:16]));
            state_in  = ST_DIFF;
         end
         ST_DIFF: begin
            diff_in  = DW'(target_ff) - DW'(q_sel);
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            delta_in = scale_prod >>> 16;
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            mem_addr = cur_ff;
            mem_we   = 1'b1;
            chrow_in = (nxt_ff == cur_ff) ? new_row : nrow_ff;
            cur_in   = nxt_ff;
            step_in  = step_inc;
            if (done_ff) begin
               if (reward_ff == 8'sd1 && eps_ff > cfg.eps_floor) begin
                  state_in = ST_DECAY;
               end else begin
                  rsp_valid_in    = 1'b1;
                  rsp_action_in   = '0;
                  rsp_explored_in = 1'b0;
                  rsp_over_in     = 1'b1;
                  state_in        = ST_IDLE;
               end
            end else if (step_inc >= cfg.max_steps) begin
               rsp_valid_in    = 1'b1;
               rsp_action_in   = '0;
               rsp_explored_in = 1'b0;
               rsp_over_in     = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_DRAW1;
            end
         end
         ST_DRAW1: begin
            rng_in = draw;
            if (draw > eps_ff) begin
               last_act_in     = row_argmax(chrow_ff);
               rsp_valid_in    = 1'b1;
               rsp_action_in   = row_argmax(chrow_ff);
               rsp_explored_in = 1'b0;
               rsp_over_in     = 1'b0;
               state_in        = ST_IDLE;
            end else begin
               state_in = ST_DRAW2;
            end
         end
         ST_DRAW2: begin
            rng_in          = draw;
            last_act_in     = act_mod(draw);
            rsp_valid_in    = 1'b1;
            rsp_action_in   = act_mod(draw);
            rsp_explored_in = 1'b1;
            rsp_over_in     = 1'b0;
            state_in        = ST_IDLE;
         end
         ST_DECAY: begin
            eps_in          = decay_prod[46:16];
            rsp_valid_in    = 1'b1;
            rsp_action_in   = '0;
            rsp_explored_in = 1'b0;
            rsp_over_in     = 1'b1;
            state_in        = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      rd_ff <= mem[mem_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         new_run_ff   <= 1'b0;
         cur_ff       <= '0;
         last_act_ff  <= '0;
         eps_ff       <= EPS_START_RST;
         rng_ff       <= RNG_RST;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         new_run_ff   <= new_run_in;
         cur_ff       <= cur_in;
         last_act_ff  <= last_act_in;
         eps_ff       <= eps_in;
         rng_ff       <= rng_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff          <= nxt_in;
      reward_ff       <= reward_in;
      done_ff         <= done_in;
      nrow_ff         <= nrow_in;
      crow_ff         <= crow_in;
      chrow_ff        <= chrow_in;
      maxq_ff         <= maxq_in;
      target_ff       <= target_in;
      diff_ff         <= diff_in;
      delta_ff        <= delta_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_explored_ff <= rsp_explored_in;
      rsp_over_ff     <= rsp_over_in;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_action       = rsp_action_ff;
   assign rsp_explored     = rsp_explored_ff;
   assign rsp_episode_over = rsp_over_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && mode != MODE_NONE |=> busy)
      else $error("accepted item did not raise busy");

   a_over_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_episode_over |-> rsp_action == 2'd0 && !rsp_explored)
      else $error("episode end carries an action");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == ST_CLEAR || state_ff == ST_WRITE)
      else $error("table written outside clear or update");

   a_action_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_action) < NUM_ACTIONS)
      else $error("action out of range");

endmodule
`default_nettype wire

### tb/tabular_q_learning_agent_unit_checker.sv
// tabular_q_learning_agent_unit_checker: predicts the agent's replies and compares them
// depends on tqla_pkg; watches the request, response and register ports of the agent
`timescale 1ns / 100ps
module tabular_q_learning_agent_unit_checker (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic                        busy,
   input  wire logic [1:0]                  req_mode,
   input  wire logic [5:0]                  req_next_state,
   input  wire logic signed [7:0]           req_reward,
   input  wire logic                        req_done_req,
   input  wire logic                        rsp_valid,
   input  wire logic [1:0]                  rsp_action,
   input  wire logic                        rsp_explored,
   input  wire logic                        rsp_episode_over,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [tqla_pkg::CSR_AW-1:0] paddr,
   input  wire logic [31:0]                 pwdata,
   input  wire logic                        pready,
   output int                               pending,
   output int                               errors
);
   import tqla_pkg::*;

   typedef struct packed {
      logic [1:0] action;
      logic       explored;
      logic       over;
   } decision_type;

   decision_type decisions_due[$];

   logic signed [31:0] qtab [0:255];
   logic [5:0]  cur_state;
   logic [1:0]  last_act;
   logic [30:0] eps;
   logic [30:0] rng;
   logic [15:0] steps;
   logic [15:0] alpha, gamma_q, decay, step_limit;
   logic [30:0] eps_start, eps_floor, seed;

   assign pending = decisions_due.size();

   task automatic lcg_draw(output logic [30:0] r);
      longint unsigned x;
      x = longint'(rng) * 64'd1103515245 + 64'd12345;
      rng = x[30:0];
      r = rng;
   endtask

   task automatic pick_action(output decision_type dec);
      logic [30:0] r;
      longint best;
      begin
         lcg_draw(r);
         dec = '0;
         if (r > eps) begin
            best = 0;
            for (int i = 0; i < 4; i++)
               if (longint'(qtab[cur_state*4+i]) > best) begin
                  best = qtab[cur_state*4+i];
                  last_act = i[1:0];
               end
            if (best == 0) last_act = 2'd0;
         end else begin
            lcg_draw(r);
            last_act = r[1:0];
            dec.explored = 1'b1;
         end
         dec.action = last_act;
      end
   endtask

   task automatic apply_feedback(input logic [5:0] ns, input logic signed [7:0] rew,
                                 input logic done, output decision_type dec);
      longint maxq, disc, target, q, d, nq;
      int slot;
      begin
         maxq = 0;
         for (int i = 0; i < 4; i++)
            if (longint'(qtab[ns*4+i]) > maxq) maxq = qtab[ns*4+i];
         disc = (maxq * longint'(gamma_q)) >>> 16;
         target = longint'(rew) * 65536 + disc;
         slot = cur_state * 4 + last_act;
         q = qtab[slot];
         d = target - q;
         nq = q + ((d * longint'(alpha)) >>> 16);
         if (nq > 64'sd2147483647) nq = 64'sd2147483647;
         if (nq < -64'sd2147483648) nq = -64'sd2147483648;
         qtab[slot] = nq[31:0];
         cur_state = ns;
         if (steps != 16'hFFFF) steps++;
         dec = '0;
         if (done) begin
            if (rew == 8'sd1 && eps > eps_floor)
               eps = 31'((longint'(eps) * longint'(decay)) >> 16);
            dec.over = 1'b1;
         end else if (steps >= step_limit) begin
            dec.over = 1'b1;
         end else begin
            pick_action(dec);
         end
      end
   endtask

   always @(posedge clock) begin
      decision_type dec, want;
      if (reset) begin
         foreach (qtab[i]) qtab[i] = '0;
         cur_state = '0; last_act = '0; steps = '0;
         eps = EPS_START_RST; rng = RNG_RST;
         alpha = STEP_SIZE_RST; gamma_q = DISCOUNT_RST; eps_start = EPS_START_RST;
         eps_floor = EPS_FLOOR_RST; decay = EPS_DECAY_RST; step_limit = MAX_STEPS_RST;
         seed = RNG_SEED_RST;
         decisions_due.delete();
         errors = 0;
      end else begin
         if (rsp_valid) begin
            if (decisions_due.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result transfer at %0t", $realtime);
            end else begin
               want = decisions_due.pop_front();
               if (want != {rsp_action, rsp_explored, rsp_episode_over}) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch at %0t: action %0d/%0d explored %0d/%0d over %0d/%0d",
                              $realtime, want.action, rsp_action, want.explored,
                              rsp_explored, want.over, rsp_episode_over);
               end
            end
         end
         if (psel && penable && pwrite && pready)
            case (reg_index_type'(paddr[4:2]))
               REG_STEP_SIZE:  alpha = pwdata[15:0];
               REG_DISCOUNT:   gamma_q = pwdata[15:0];
               REG_EPS_START:  eps_start = pwdata[30:0];
               REG_EPS_FLOOR:  eps_floor = pwdata[30:0];
               REG_EPS_DECAY:  decay = pwdata[15:0];
               REG_MAX_STEPS:  step_limit = pwdata[15:0];
               REG_RNG_SEED:   seed = pwdata[30:0];
               default: ;
            endcase
         if (start && !busy) begin
            case (mode_type'(req_mode))
               MODE_NEW_RUN: begin
                  foreach (qtab[i]) qtab[i] = '0;
                  eps = eps_start; rng = seed;
                  cur_state = '0; steps = '0;
                  pick_action(dec);
               end
               MODE_BEGIN: begin
                  cur_state = '0; steps = '0;
                  pick_action(dec);
               end
               MODE_FEEDBACK: apply_feedback(req_next_state, req_reward, req_done_req, dec);
               default: dec = '0;
            endcase
            decisions_due.push_back(dec);
         end
      end
   end

endmodule

### tb/tabular_q_learning_agent_unit_test.sv
// tabular_q_learning_agent_unit_test: drives episodes and register settings into the agent
// depends on tqla_pkg, tabular_q_learning_agent_unit and tabular_q_learning_agent_unit_checker
`timescale 1ns / 100ps
module tabular_q_learning_agent_unit_test;
   import tqla_pkg::*;

   logic clock, reset, start, busy;
   logic [1:0] req_mode;
   logic [5:0] req_next_state;
   logic signed [7:0] req_reward;
   logic req_done_req;
   logic rsp_valid, rsp_explored, rsp_episode_over;
   logic [1:0] rsp_action;
   logic psel, penable, pwrite, pready;
   logic [CSR_AW-1:0] paddr;
   logic [31:0] pwdata, prdata;
   int pending, errors;
   int items_sent, idle_pct, span, quiet_cycles;

   tabular_q_learning_agent_unit i_dut (.*);
   tabular_q_learning_agent_unit_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 20000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic csr_write(input reg_index_type idx, input logic [31:0] val);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; paddr = CSR_AW'(idx) << 2; pwdata = val;
      @(negedge clock);
      penable = 1'b1;
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic send(input mode_type m, input logic [5:0] ns, input logic signed [7:0] rew,
                       input logic done);
      @(negedge clock);
      start = 1'b1; req_mode = m; req_next_state = ns; req_reward = rew; req_done_req = done;
      do @(posedge clock); while (busy);
      items_sent++;
      while ($urandom_range(99, 0) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
      end
   endtask

   function automatic logic signed [7:0] pick_reward();
      case ($urandom_range(7, 0))
         0: return -8'sd128;
         1: return 8'sd127;
         2: return 8'sd1;
         3: return 8'($urandom);
         default: return 8'($urandom_range(6, 0) - 3);
      endcase
   endfunction

   task automatic play_episode();
      int n;
      logic done;
      logic signed [7:0] rew;
      if ($urandom_range(9, 0) == 0) send(MODE_NEW_RUN, 6'($urandom), 8'($urandom), 1'($urandom));
      else send(MODE_BEGIN, 6'($urandom), 8'($urandom), 1'($urandom));
      n = $urandom_range(30, 1);
      for (int i = 0; i < n; i++) begin
         done = (i == n - 1) && ($urandom_range(3, 0) != 0);
         rew = (done && $urandom_range(1, 0)) ? 8'sd1 : pick_reward();
         send(MODE_FEEDBACK, 6'($urandom_range(span, 0)), rew, done);
      end
      // noise: unused mode or feedback past the end
      if ($urandom_range(4, 0) == 0)
         send($urandom_range(1, 0) ? MODE_NONE : MODE_FEEDBACK, 6'($urandom), 8'($urandom),
              1'($urandom));
   endtask

   // drop start so the last item is not taken again, then drain
   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      int phase, phase_end;
      start = 0; req_mode = 0; req_next_state = 0; req_reward = 0; req_done_req = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      items_sent = 0; idle_pct = 0; span = 63;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: default settings, field extremes, goal, step limit, unused mode
      send(MODE_NEW_RUN, 6'd0, 8'sd0, 1'b0);
      send(MODE_FEEDBACK, 6'd63, 8'sd127, 1'b0);
      send(MODE_FEEDBACK, 6'd0, -8'sd128, 1'b0);
      send(MODE_FEEDBACK, 6'd63, 8'sd1, 1'b1);
      send(MODE_FEEDBACK, 6'd5, 8'sd3, 1'b0);
      send(MODE_NONE, 6'd63, -8'sd1, 1'b1);
      send(MODE_BEGIN, 6'd0, 8'sd0, 1'b0);
      send(MODE_FEEDBACK, 6'd1, -8'sd5, 1'b1);
      settle();
      csr_write(REG_MAX_STEPS, 32'd2);
      csr_write(REG_EPS_START, 32'd0);
      send(MODE_NEW_RUN, 6'd0, 8'sd0, 1'b0);
      send(MODE_FEEDBACK, 6'd0, 8'sd100, 1'b0);
      send(MODE_FEEDBACK, 6'd0, 8'sd100, 1'b0);
      send(MODE_FEEDBACK, 6'd2, 8'sd100, 1'b0);
      send(MODE_BEGIN, 6'd0, 8'sd0, 1'b0);
      send(MODE_FEEDBACK, 6'd0, 8'sd1, 1'b0);

      phase = 0;
      while (items_sent < 480) begin
         settle();
         case (phase)
            0: begin
               csr_write(REG_STEP_SIZE, 32'hFFFF); csr_write(REG_DISCOUNT, 32'hFFFF);
               csr_write(REG_EPS_START, 32'd0); csr_write(REG_EPS_FLOOR, 32'd0);
               csr_write(REG_EPS_DECAY, 32'hFFFF); csr_write(REG_MAX_STEPS, 32'd1);
               csr_write(REG_RNG_SEED, 32'd0);
            end
            1: begin
               csr_write(REG_STEP_SIZE, 32'd0); csr_write(REG_DISCOUNT, 32'd0);
               csr_write(REG_EPS_START, 32'h7FFF_FFFF); csr_write(REG_EPS_FLOOR, 32'h7FFF_FFFF);
               csr_write(REG_EPS_DECAY, 32'd0); csr_write(REG_MAX_STEPS, 32'hFFFF);
               csr_write(REG_RNG_SEED, 32'h7FFF_FFFF);
            end
            default: begin
               csr_write(REG_STEP_SIZE, $urandom_range(65535, 0));
               csr_write(REG_DISCOUNT, $urandom_range(65535, 30000));
               csr_write(REG_EPS_START, $urandom & 32'h7FFF_FFFF);
               csr_write(REG_EPS_FLOOR, $urandom_range(200000000, 0));
               csr_write(REG_EPS_DECAY, $urandom_range(65535, 40000));
               csr_write(REG_MAX_STEPS, $urandom_range(20, 0));
               csr_write(REG_RNG_SEED, $urandom & 32'h7FFF_FFFF);
            end
         endcase
         case (phase % 4)
            0: idle_pct = 0;
            1: idle_pct = 85;
            2: idle_pct = 17;
            default: idle_pct = 0;
         endcase
         span = (phase % 3 == 0) ? 3 : 63;
         send(MODE_NEW_RUN, 6'($urandom), 8'($urandom), 1'($urandom));
         phase_end = items_sent + 75;
         while (items_sent < phase_end) play_episode();
         phase++;
      end

      @(negedge clock);
      start = 1'b0;
      settle();
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule
